// ===== src/bustk_pkg.sv =====
// Package for the bounded undo stack: sizes, operation and register codes,
// payload and control structs, and ring index arithmetic.
// Depends on nothing; bustk_seq and the top level use it.
package bustk_pkg;

   localparam int CAPACITY     = 16;
   localparam int HANDLE_WIDTH = 32;
   localparam int PTR_W        = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W        = $clog2(CAPACITY + 1);
   localparam int FAIL_W       = 8;
   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = 8;

   localparam logic [1:0] MODE_PUSH  = 2'd0;
   localparam logic [1:0] MODE_POP   = 2'd1;
   localparam logic [1:0] MODE_CLEAR = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_MAX_FAILURES    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CAPTURE_PRESENT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RESTORE_PRESENT = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RELEASE_PRESENT = 2'd3;

   localparam logic [FAIL_W-1:0] FAIL_SAT       = {FAIL_W{1'b1}};
   localparam logic [FAIL_W-1:0] MAX_FAIL_RESET = 8'd3;

   typedef struct packed {
      logic [1:0]              mode;
      logic [HANDLE_WIDTH-1:0] snapshot_handle;
      logic                    restore_ok;
   } req_type;

   typedef struct packed {
      logic [HANDLE_WIDTH-1:0] handle_out;
      logic                    release_valid;
      logic                    restore_valid;
      logic                    success;
      logic                    disabled_flag;
      logic [CNT_W-1:0]        depth;
      logic                    last;
   } rsp_type;

   typedef struct packed {
      logic [FAIL_W-1:0] max_failures;
      logic              capture_present;
      logic              restore_present;
      logic              release_present;
   } cfg_type;

   // Ring slot at offset cnt from ptr; the sum stays below twice the capacity.
   function automatic logic [PTR_W-1:0] ring_add(input logic [PTR_W-1:0] ptr,
                                                  input logic [CNT_W-1:0] cnt);
      logic [CNT_W:0] sum;
      sum = {{(CNT_W + 1 - PTR_W){1'b0}}, ptr} + {1'b0, cnt};
      if (sum >= (CNT_W + 1)'(CAPACITY)) begin
         sum = sum - (CNT_W + 1)'(CAPACITY);
      end
      return sum[PTR_W-1:0];
   endfunction

endpackage

// ===== src/bustk_ram.sv =====
// Generic single-write, single-read synchronous RAM with a registered read port.
// Depends on nothing.
module bustk_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/bustk_seq.sv =====
// Operation sequencer of the undo stack: ring pointers, failure counter, disabled
// flag, and the read-modify-write steps on the handle RAM. Uses bustk_pkg, bustk_ram.
module bustk_seq (
   input  logic              clock,
   input  logic              reset,
   input  bustk_pkg::cfg_type cfg,
   input  logic              req_valid,
   output logic              req_ready,
   input  bustk_pkg::req_type req_payload,
   output logic              res_valid,
   input  logic              res_ready,
   output bustk_pkg::rsp_type res_payload
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_EXEC  = 3'd1;
   localparam logic [2:0] ST_PUSH2 = 3'd2;
   localparam logic [2:0] ST_CLR   = 3'd3;
   localparam logic [2:0] ST_FIN   = 3'd4;

   logic [2:0]                          state_ff, state_in;
   bustk_pkg::req_type                  op_ff, op_in;
   logic [bustk_pkg::CNT_W-1:0]         count_ff, count_in;
   logic [bustk_pkg::PTR_W-1:0]         oldest_ff, oldest_in;
   logic [bustk_pkg::FAIL_W-1:0]        fail_ff, fail_in;
   logic                                disabled_ff, disabled_in;

   logic                                wr_en;
   logic [bustk_pkg::PTR_W-1:0]         wr_addr;
   logic                                rd_en;
   logic [bustk_pkg::PTR_W-1:0]         rd_addr;
   logic [bustk_pkg::HANDLE_WIDTH-1:0]  rd_data;
   logic [bustk_pkg::FAIL_W-1:0]        fail_sat;
   logic [bustk_pkg::CNT_W-1:0]         count_dec;
   logic [bustk_pkg::PTR_W-1:0]         oldest_inc;

   bustk_ram #(
      .WIDTH(bustk_pkg::HANDLE_WIDTH),
      .DEPTH(bustk_pkg::CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (op_ff.snapshot_handle),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign fail_sat   = (fail_ff == bustk_pkg::FAIL_SAT) ? fail_ff : fail_ff + 1'b1;
   assign count_dec  = count_ff - 1'b1;
   assign oldest_inc = bustk_pkg::ring_add(oldest_ff, bustk_pkg::CNT_W'(1));

   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      count_in    = count_ff;
      oldest_in   = oldest_ff;
      fail_in     = fail_ff;
      disabled_in = disabled_ff;
      req_ready   = 1'b0;
      res_valid   = 1'b0;
      wr_en       = 1'b0;
      wr_addr     = bustk_pkg::ring_add(oldest_ff, count_ff);
      rd_en       = 1'b0;
      rd_addr     = oldest_ff;
      res_payload               = '0;
      res_payload.disabled_flag = disabled_ff;
      res_payload.depth         = count_ff;
      res_payload.last          = 1'b1;

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op_in    = req_payload;
               rd_en    = 1'b1;
               state_in = ST_EXEC;
               if (req_payload.mode == bustk_pkg::MODE_POP) begin
                  rd_addr = bustk_pkg::ring_add(oldest_ff, count_dec);
               end
            end
         end
         ST_EXEC: begin
            case (op_ff.mode)
               bustk_pkg::MODE_PUSH: begin
                  res_valid = 1'b1;
                  if (disabled_ff || !cfg.capture_present) begin
                     if (res_ready) begin
                        state_in = ST_IDLE;
                     end
                  end else if (op_ff.snapshot_handle == '0) begin
                     res_payload.disabled_flag = disabled_ff ||
                                                 (fail_sat >= cfg.max_failures);
                     if (res_ready) begin
                        fail_in     = fail_sat;
                        disabled_in = res_payload.disabled_flag;
                        state_in    = ST_IDLE;
                     end
                  end else if (count_ff >= bustk_pkg::CNT_W'(bustk_pkg::CAPACITY)) begin
                     res_payload.handle_out    = rd_data;
                     res_payload.release_valid = 1'b1;
                     res_payload.success       = 1'b1;
                     res_payload.depth         = count_dec;
                     res_payload.last          = 1'b0;
                     if (res_ready) begin
                        fail_in   = '0;
                        count_in  = count_dec;
                        oldest_in = oldest_inc;
                        state_in  = ST_PUSH2;
                     end
                  end else begin
                     res_payload.success = 1'b1;
                     res_payload.depth   = count_ff + 1'b1;
                     if (res_ready) begin
                        wr_en    = 1'b1;
                        fail_in  = '0;
                        count_in = count_ff + 1'b1;
                        state_in = ST_IDLE;
                     end
                  end
               end
               bustk_pkg::MODE_POP: begin
                  res_valid = 1'b1;
                  if (!(disabled_ff || count_ff == '0 || !cfg.restore_present)) begin
                     res_payload.handle_out    = rd_data;
                     res_payload.release_valid = 1'b1;
                     res_payload.restore_valid = 1'b1;
                     res_payload.success       = op_ff.restore_ok;
                     res_payload.disabled_flag = !op_ff.restore_ok;
                     res_payload.depth         = count_dec;
                     if (res_ready) begin
                        count_in    = count_dec;
                        disabled_in = !op_ff.restore_ok;
                     end
                  end
                  if (res_ready) begin
                     state_in = ST_IDLE;
                  end
               end
               bustk_pkg::MODE_CLEAR: begin
                  disabled_in = 1'b0;
                  fail_in     = '0;
                  if (cfg.release_present && count_ff != '0) begin
                     state_in = ST_CLR;
                  end else begin
                     state_in = ST_FIN;
                  end
               end
               default: begin
                  res_valid = 1'b1;
                  if (res_ready) begin
                     state_in = ST_IDLE;
                  end
               end
            endcase
         end
         ST_PUSH2: begin
            res_valid           = 1'b1;
            res_payload.success = 1'b1;
            res_payload.depth   = count_ff + 1'b1;
            if (res_ready) begin
               wr_en    = 1'b1;
               count_in = count_ff + 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_CLR: begin
            res_valid                 = 1'b1;
            res_payload.handle_out    = rd_data;
            res_payload.release_valid = 1'b1;
            res_payload.success       = 1'b1;
            res_payload.depth         = count_dec;
            res_payload.last          = 1'b0;
            if (res_ready) begin
               count_in  = count_dec;
               oldest_in = oldest_inc;
               if (count_dec != '0) begin
                  rd_en   = 1'b1;
                  rd_addr = oldest_inc;
               end else begin
                  state_in = ST_FIN;
               end
            end
         end
         ST_FIN: begin
            res_valid           = 1'b1;
            res_payload.success = 1'b1;
            res_payload.depth   = '0;
            if (res_ready) begin
               count_in  = '0;
               oldest_in = '0;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         count_ff    <= '0;
         oldest_ff   <= '0;
         fail_ff     <= '0;
         disabled_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         oldest_ff   <= oldest_in;
         fail_ff     <= fail_in;
         disabled_ff <= disabled_in;
      end
      op_ff <= op_in;
   end

endmodule

// ===== src/bounded_undo_stack_drop_oldest_core.sv =====
// Top level of the bounded undo stack: configuration registers, output register
// and the operation sequencer. Uses bustk_pkg and bustk_seq.
//
// Usage. An operation (push, pop or clear) is a transfer on the req_ channel.
// Its results leave as transfers on the rsp_ channel, the final one marked by
// last. Configuration is written through csr_wr_en, csr_index and csr_wr_data
// while the block is idle; the user must keep to this, as the block itself does
// not enforce it. Each write is registered before it takes effect. A push, pop
// or refused operation is accepted in ST_IDLE, where the handle RAM is read;
// its result is formed in ST_EXEC and registered on rsp_. A push onto a full
// stack gives a second result from ST_PUSH2. A clear forms no result in
// ST_EXEC; with releases enabled and a non-empty stack, ST_CLR gives one
// release result per entry, one RAM read per released entry, and ST_FIN then
// gives the final result.
// Only one operation is in flight; req_ready stays low until its last result
// has entered the output register. When the receiver stalls, the result waits
// in the output register and the sequencer holds its step.
// Reset empties the stack, zeroes the failure count, enables the stack and
// restores the register defaults; the handle RAM itself is not cleared.
module bounded_undo_stack_drop_oldest_core (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  bustk_pkg::req_type                    req_payload,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output bustk_pkg::rsp_type                    rsp_payload,
   input  logic                                  csr_wr_en,
   input  logic [bustk_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [bustk_pkg::CSR_DATA_W-1:0]      csr_wr_data
);

   bustk_pkg::cfg_type cfg_ff, cfg_in;
   bustk_pkg::rsp_type rsp_ff;
   logic               rsp_valid_ff;
   logic               res_valid;
   logic               res_ready;
   bustk_pkg::rsp_type res_payload;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            bustk_pkg::CSR_MAX_FAILURES:    cfg_in.max_failures    = csr_wr_data;
            bustk_pkg::CSR_CAPTURE_PRESENT: cfg_in.capture_present = csr_wr_data[0];
            bustk_pkg::CSR_RESTORE_PRESENT: cfg_in.restore_present = csr_wr_data[0];
            bustk_pkg::CSR_RELEASE_PRESENT: cfg_in.release_present = csr_wr_data[0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_failures    <= bustk_pkg::MAX_FAIL_RESET;
         cfg_ff.capture_present <= 1'b1;
         cfg_ff.restore_present <= 1'b1;
         cfg_ff.release_present <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign res_ready = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_ready) begin
         rsp_valid_ff <= res_valid;
      end
      if (res_ready && res_valid) begin
         rsp_ff <= res_payload;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   bustk_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .res_valid   (res_valid),
      .res_ready   (res_ready),
      .res_payload (res_payload)
   );

`ifndef SYNTHESIS
   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.depth <= bustk_pkg::CNT_W'(bustk_pkg::CAPACITY))
      else $error("result depth exceeds the capacity");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while an operation is in flight");

   a_no_accept_mid_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.last |-> !req_ready)
      else $error("request taken before the last result of a run");

   a_release_enabled: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.release_valid && !rsp_payload.restore_valid
      |-> !rsp_payload.disabled_flag)
      else $error("drop or clear release reported a disabled stack");
`endif

endmodule
